@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define NRSR_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) else $error(msg);
// Antecedent on this edge implies consequent on the next edge.
`define NRSR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NRSR_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr, msg)
`define NRSR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

@@ sv/nrsr_pkg.sv @@
// Types and constants for the nearest-range sector ranker.
package nrsr_pkg;

    localparam int DIST_W = 16;
    localparam int TAG_W  = 6;
    localparam int RANK_W = 3;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] dist_val;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

@@ sv/nrsr_cell.sv @@
// One compare-and-shift cell of the sorted top-K chain.
module nrsr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ins_en,
    input  logic                          clear,
    input  logic [nrsr_pkg::DIST_W-1:0]   new_dist,
    input  logic [nrsr_pkg::TAG_W-1:0]    new_tag,
    input  logic                          prev_cond,
    input  nrsr_pkg::entry_t              prev_entry,
    output logic                          cond,
    output nrsr_pkg::entry_t              entry,
    output nrsr_pkg::entry_t              entry_next
);
    import nrsr_pkg::*;

    logic              valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              valid_next;

    // New reading belongs at or before this slot (ties go ahead).
    assign cond = !valid_reg || (new_dist <= dist_reg);

    assign entry = '{valid: valid_reg, dist_val: dist_reg, tag: tag_reg};

    always_comb
    begin
        if (prev_cond)
        begin
            entry_next = prev_entry;
        end
        else if (cond)
        begin
            entry_next = '{valid: 1'b1, dist_val: new_dist, tag: new_tag};
        end
        else
        begin
            entry_next = entry;
        end
    end

    assign valid_next = clear ? 1'b0 : entry_next.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ins_en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            dist_reg <= entry_next.dist_val;
            tag_reg  <= entry_next.tag;
        end
    end

endmodule

@@ sv/nrsr_drain_slot.sv @@
// One slot of the result drain chain: loads a snapshot, shifts toward the output.
module nrsr_drain_slot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  nrsr_pkg::entry_t  snap,
    input  logic              shift,
    input  nrsr_pkg::entry_t  upstream,
    output nrsr_pkg::entry_t  entry
);
    import nrsr_pkg::*;

    logic              valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TAG_W-1:0]  tag_reg;

    assign entry = '{valid: valid_reg, dist_val: dist_reg, tag: tag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= snap.valid;
        end
        else if (shift)
        begin
            valid_reg <= upstream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dist_reg <= snap.dist_val;
            tag_reg  <= snap.tag;
        end
        else if (shift)
        begin
            dist_reg <= upstream.dist_val;
            tag_reg  <= upstream.tag;
        end
    end

endmodule

@@ sv/nearest_range_sector_ranker.sv @@
// Top level of the nearest-range sector ranker.
// Takes one range reading per sector transaction, tags it with its sector
// number (0 upward within a frame) and keeps the TOP_K nearest readings in a
// chain of compare cells sorted by ascending distance; a new reading goes
// ahead of stored readings of equal distance. Only the TOP_K nearest are
// kept, since readings ranked below TOP_K can never rise into the top.
// A frame ends on a transaction with frame_end set or on the NUM_SECTORS-th
// reading. On that transaction the sorted top entries are copied into an
// output drain chain and the sort chain is emptied, so the next reading
// starts a new frame as sector 0. The drain chain then presents
// min(readings, TOP_K) result transactions in rank order, rank 0 nearest,
// with last_result set on the final one.
// Rate: a reading is taken every cycle while in_stall is low (each cell
// compares and shifts on every accepted reading). After a frame-ending
// transaction in_stall stays high while the drain chain empties, one result
// per cycle when out_stall is low; out_stall holds the drain.
module nearest_range_sector_ranker #(
    parameter int NUM_SECTORS = 36,
    parameter int TOP_K       = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nrsr_pkg::DIST_W-1:0]   distance,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nrsr_pkg::RANK_W-1:0]   rank,
    output logic [nrsr_pkg::TAG_W-1:0]    sector_index,
    output logic [nrsr_pkg::DIST_W-1:0]   ranked_distance,
    output logic                          last_result
);
    import nrsr_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(NUM_SECTORS);

    // Sector counter for the current frame.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;

    logic in_xact;
    logic out_xact;
    logic frame_done;
    logic [TAG_W-1:0] new_tag;

    // Sort chain: cond/entry of cell i feed cell i+1.
    logic   [TOP_K-1:0] cell_cond;
    entry_t             cell_entry [TOP_K];
    entry_t             cell_snap  [TOP_K];
    logic   [TOP_K-1:0] cell_valid;

    // Drain chain, with an always-empty slot past the end.
    entry_t drain_entry [TOP_K+1];

    assign in_xact    = in_valid && !in_stall;
    assign out_xact   = out_valid && !out_stall;
    assign frame_done = frame_end || (count_reg == CNT_W'(NUM_SECTORS - 1));
    assign new_tag    = TAG_W'(count_reg);

    // Hold off new readings while a frame's results drain.
    assign in_stall = drain_entry[0].valid;

    genvar gi;
    generate
        for (gi = 0; gi < TOP_K; gi++)
        begin : g_sort
            logic   pcond;
            entry_t pentry;
            if (gi == 0)
            begin : g_head
                assign pcond  = 1'b0;
                assign pentry = '0;
            end
            else
            begin : g_body
                assign pcond  = cell_cond[gi-1];
                assign pentry = cell_entry[gi-1];
            end

            nrsr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins_en     (in_xact),
                .clear      (frame_done),
                .new_dist   (distance),
                .new_tag    (new_tag),
                .prev_cond  (pcond),
                .prev_entry (pentry),
                .cond       (cell_cond[gi]),
                .entry      (cell_entry[gi]),
                .entry_next (cell_snap[gi])
            );

            assign cell_valid[gi] = cell_entry[gi].valid;

            nrsr_drain_slot u_slot (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (in_xact && frame_done),
                .snap     (cell_snap[gi]),
                .shift    (out_xact),
                .upstream (drain_entry[gi+1]),
                .entry    (drain_entry[gi])
            );
        end
    endgenerate

    assign drain_entry[TOP_K] = '0;

    always_comb
    begin
        count_next = count_reg;
        if (in_xact)
        begin
            count_next = frame_done ? '0 : count_reg + 1'b1;
        end
    end

    // Rank restarts at each snapshot and steps with every result taken.
    always_comb
    begin
        rank_next = rank_reg;
        if (in_xact && frame_done)
        begin
            rank_next = '0;
        end
        else if (out_xact)
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    assign out_valid       = drain_entry[0].valid;
    assign rank            = rank_reg;
    assign sector_index    = drain_entry[0].tag;
    assign ranked_distance = drain_entry[0].dist_val;
    assign last_result     = !drain_entry[1].valid;

    // Occupied cells always form a prefix of the sort chain.
    `NRSR_ASSERT_ALWAYS(a_sort_prefix, clk, rst_n,
        (cell_valid & (cell_valid + 1'b1)) == '0, "sort chain valid bits not a prefix")
    // A frame-ending reading always yields at least one result.
    `NRSR_ASSERT_NEXT(a_frame_emits, clk, rst_n, in_xact && frame_done,
        out_valid && (rank == '0), "frame end produced no rank-0 result")
    // A result that is not the last one is followed by another.
    `NRSR_ASSERT_NEXT(a_drain_cont, clk, rst_n, out_xact && !last_result,
        out_valid, "result chain broke before last_result")
    // Sort chain is empty when a frame's drain starts.
    `NRSR_ASSERT_ALWAYS(a_empty_drain, clk, rst_n,
        !(out_valid && (rank == '0)) || (cell_valid == '0) || $past(out_valid),
        "sort chain not cleared at frame end")

endmodule
